// ===== rtl/core/tkst_pkg.sv =====
`default_nettype none
package tkst_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_FINAL,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic load;
		logic walk;
		logic fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic reject;
		logic walk_done;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/core/top_k_score_table.sv =====
// A read or an unused mode goes from idle to the reply state and its done strobe; insert and remove
// walk the n stored entries through one read port, one a cycle. A full table first checks its
// lowest score: a reject goes to the reply without a walk, otherwise the CAPACITY - 1 upper
// entries are walked.
// One operation is in flight at a time; start is taken again in the cycle the strobe shows.
// Reset empties the table and clears the controller; table contents are not cleared.
`default_nettype none
module top_k_score_table #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 16,
	parameter int SCORE_BITS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire  [1:0]          mode,
	input  wire  [15:0]         player_key,
	input  wire  signed [31:0]  new_score,
	input  wire  [3:0]          slot_index,
	output logic                done,
	output logic                accepted,
	output logic [4:0]          entry_count,
	output logic                read_valid,
	output logic [15:0]         read_key,
	output logic signed [31:0]  read_score
);

	tkst_pkg::cmd_t    cmd;
	tkst_pkg::status_t status;

	tkst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	tkst_dp #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.SCORE_BITS (SCORE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (mode),
		.player_key  (player_key),
		.new_score   (new_score),
		.slot_index  (slot_index),
		.status      (status),
		.done        (done),
		.accepted    (accepted),
		.entry_count (entry_count),
		.read_valid  (read_valid),
		.read_key    (read_key),
		.read_score  (read_score)
	);

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted start did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done beat without an operation in flight");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done beat repeated");

	a_acc_not_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(accepted && read_valid))
		else $error("insert and read reported in one beat");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tkst_dp.sv =====
`default_nettype none
module tkst_dp #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BITS   = 16,
	parameter int SCORE_BITS = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire tkst_pkg::cmd_t    cmd,
	input  wire  [1:0]             mode,
	input  wire  [15:0]            player_key,
	input  wire  signed [31:0]     new_score,
	input  wire  [3:0]             slot_index,
	output tkst_pkg::status_t      status,
	output logic                   done,
	output logic                   accepted,
	output logic [4:0]             entry_count,
	output logic                   read_valid,
	output logic [15:0]            read_key,
	output logic signed [31:0]     read_score
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > 4) ? CW : 4;

	logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
	logic [SCORE_BITS-1:0] score_mem [CAPACITY];

	logic [KEY_BITS-1:0]   rd_key_q;
	logic [SCORE_BITS-1:0] rd_score_q;
	logic [KEY_BITS-1:0]   carry_key_q;
	logic [SCORE_BITS-1:0] carry_score_q;
	tkst_pkg::mode_t       op_mode_q;
	logic [3:0]            op_slot_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         lim_q;
	logic [CW-1:0]         rd_ptr_q;
	logic [CW-1:0]         proc_ptr_q;
	logic [CW-1:0]         wr_ptr_q;
	logic                  pv_q;
	logic                  placed_q;
	logic                  acc_q;
	logic                  done_q;

	logic                  full;
	logic                  less_e;
	logic                  ins_wr;
	logic                  keep;
	logic                  more;
	logic                  rv;
	logic [AW-1:0]         raddr;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [KEY_BITS-1:0]   wkey;
	logic [SCORE_BITS-1:0] wscore;

	assign full   = (count_q == CW'(CAPACITY));
	assign less_e = ($signed(rd_score_q) < $signed(carry_score_q));
	assign ins_wr = placed_q || less_e;
	assign keep   = (rd_key_q != carry_key_q);
	assign more   = (rd_ptr_q != lim_q);
	assign rv     = (op_mode_q == tkst_pkg::MODE_READ) && (WW'(op_slot_q) < WW'(count_q));

	assign status.full      = full;
	assign status.reject    = ($signed(carry_score_q) < $signed(rd_score_q));
	assign status.walk_done = !more && !pv_q;

	always_comb begin
		if (cmd.walk) begin
			raddr = rd_ptr_q[AW-1:0];
		end else if (mode == tkst_pkg::MODE_READ) begin
			raddr = AW'(slot_index);
		end else begin
			raddr = AW'(CAPACITY - 1);
		end
	end

	always_comb begin
		we     = 1'b0;
		waddr  = proc_ptr_q[AW-1:0];
		wkey   = carry_key_q;
		wscore = carry_score_q;
		if (cmd.walk && pv_q) begin
			if (op_mode_q == tkst_pkg::MODE_INSERT && ins_wr) begin
				we = 1'b1;
			end else if (op_mode_q == tkst_pkg::MODE_REMOVE && keep) begin
				we     = 1'b1;
				waddr  = wr_ptr_q[AW-1:0];
				wkey   = rd_key_q;
				wscore = rd_score_q;
			end
		end else if (cmd.fin && op_mode_q == tkst_pkg::MODE_INSERT) begin
			we    = 1'b1;
			waddr = lim_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		rd_key_q   <= key_mem[raddr];
		rd_score_q <= score_mem[raddr];
		if (we) begin
			key_mem[waddr]   <= wkey;
			score_mem[waddr] <= wscore;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			pv_q     <= 1'b0;
			placed_q <= 1'b0;
			acc_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				pv_q     <= 1'b0;
				placed_q <= 1'b0;
				acc_q    <= 1'b0;
			end else if (cmd.walk) begin
				if (more) begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					pv_q     <= 1'b1;
				end else begin
					pv_q <= 1'b0;
				end
				if (pv_q && op_mode_q == tkst_pkg::MODE_INSERT && ins_wr) begin
					placed_q <= 1'b1;
				end
				if (pv_q && op_mode_q == tkst_pkg::MODE_REMOVE && keep) begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (cmd.fin) begin
				if (op_mode_q == tkst_pkg::MODE_INSERT) begin
					acc_q <= 1'b1;
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end else if (op_mode_q == tkst_pkg::MODE_REMOVE) begin
					count_q <= wr_ptr_q;
				end
			end
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_mode_q     <= tkst_pkg::mode_t'(mode);
			op_slot_q     <= slot_index;
			carry_key_q   <= KEY_BITS'(player_key);
			carry_score_q <= SCORE_BITS'($unsigned(new_score));
			if (full && mode == tkst_pkg::MODE_INSERT) begin
				lim_q <= CW'(CAPACITY - 1);
			end else begin
				lim_q <= count_q;
			end
		end
		if (cmd.walk && more) begin
			proc_ptr_q <= rd_ptr_q;
		end
		if (cmd.walk && pv_q && op_mode_q == tkst_pkg::MODE_INSERT && ins_wr) begin
			carry_key_q   <= rd_key_q;
			carry_score_q <= rd_score_q;
		end
		if (cmd.emit) begin
			accepted    <= acc_q;
			entry_count <= 5'(count_q);
			read_valid  <= rv;
			read_key    <= rv ? 16'(rd_key_q) : '0;
			read_score  <= rv ? 32'(rd_score_q) : '0;
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

// ===== rtl/core/tkst_ctrl.sv =====
`default_nettype none
module tkst_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  [1:0]          mode,
	input  wire tkst_pkg::status_t status,
	output logic                busy,
	output tkst_pkg::cmd_t      cmd
);

	tkst_pkg::state_t state_q;
	tkst_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			tkst_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					case (mode)
						tkst_pkg::MODE_INSERT: begin
							state_d = status.full ? tkst_pkg::ST_CHECK : tkst_pkg::ST_WALK;
						end
						tkst_pkg::MODE_REMOVE: begin
							state_d = tkst_pkg::ST_WALK;
						end
						default: begin
							state_d = tkst_pkg::ST_REPLY;
						end
					endcase
				end
			end
			tkst_pkg::ST_CHECK: begin
				state_d = status.reject ? tkst_pkg::ST_REPLY : tkst_pkg::ST_WALK;
			end
			tkst_pkg::ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_done) begin
					state_d = tkst_pkg::ST_FINAL;
				end
			end
			tkst_pkg::ST_FINAL: begin
				cmd.fin = 1'b1;
				state_d = tkst_pkg::ST_REPLY;
			end
			tkst_pkg::ST_REPLY: begin
				cmd.emit = 1'b1;
				state_d  = tkst_pkg::ST_IDLE;
			end
			default: begin
				state_d = tkst_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int TABLE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_OPS  = 700;

	typedef struct packed {
		logic               accepted;
		logic [4:0]         entry_count;
		logic               read_valid;
		logic [15:0]        read_key;
		logic signed [31:0] read_score;
	} table_reply_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         mode;
	logic [15:0]        player_key;
	logic signed [31:0] new_score;
	logic [3:0]         slot_index;
	logic               done;
	logic               accepted;
	logic [4:0]         entry_count;
	logic               read_valid;
	logic [15:0]        read_key;
	logic signed [31:0] read_score;

	logic [15:0]        table_keys [TABLE_DEPTH];
	logic signed [31:0] table_scores [TABLE_DEPTH];
	int                 table_fill;
	table_reply_t       pending_replies [$];
	logic [15:0]        key_pool [8];
	bit                 no_gaps;
	int                 error_count;
	int                 cycle_count;

	top_k_score_table #(.CAPACITY(TABLE_DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.player_key  (player_key),
		.new_score   (new_score),
		.slot_index  (slot_index),
		.done        (done),
		.accepted    (accepted),
		.entry_count (entry_count),
		.read_valid  (read_valid),
		.read_key    (read_key),
		.read_score  (read_score)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Updates the sorted table as the block should and returns the reply it should give.
	function automatic table_reply_t apply_table_op(tkst_pkg::mode_t m, logic [15:0] k,
			logic signed [31:0] s, logic [3:0] slot);
		table_reply_t r;
		int n;
		int pos;
		int w;
		r = '0;
		if (m == tkst_pkg::MODE_INSERT) begin
			if (table_fill < TABLE_DEPTH || s >= table_scores[TABLE_DEPTH - 1]) begin
				n = (table_fill < TABLE_DEPTH) ? table_fill : TABLE_DEPTH - 1;
				pos = 0;
				while (pos < n && table_scores[pos] >= s)
					pos++;
				for (int i = n; i > pos; i--) begin
					table_keys[i]   = table_keys[i - 1];
					table_scores[i] = table_scores[i - 1];
				end
				table_keys[pos]   = k;
				table_scores[pos] = s;
				if (table_fill < TABLE_DEPTH)
					table_fill++;
				r.accepted = 1'b1;
			end
		end else if (m == tkst_pkg::MODE_REMOVE) begin
			w = 0;
			for (int i = 0; i < table_fill; i++) begin
				if (table_keys[i] != k) begin
					table_keys[w]   = table_keys[i];
					table_scores[w] = table_scores[i];
					w++;
				end
			end
			table_fill = w;
		end else if (m == tkst_pkg::MODE_READ) begin
			if (int'(slot) < table_fill) begin
				r.read_valid = 1'b1;
				r.read_key   = table_keys[slot];
				r.read_score = table_scores[slot];
			end
		end
		r.entry_count = 5'(table_fill);
		return r;
	endfunction

	// Issues one beat and waits until the block takes it; start stays high afterwards.
	task automatic issue_op(tkst_pkg::mode_t m, logic [15:0] k, logic signed [31:0] s,
			logic [3:0] slot);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		mode       <= m;
		player_key <= k;
		new_score  <= s;
		slot_index <= slot;
		do
			@(posedge clk);
		while (busy);
		pending_replies.push_back(apply_table_op(m, k, s, slot));
	endtask

	always @(posedge clk) begin
		table_reply_t got;
		table_reply_t want;
		if (arst_n && done) begin
			got = '{accepted, entry_count, read_valid, read_key, read_score};
			if (pending_replies.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected reply: accepted %0b count %0d valid %0b key %h score %0d",
						got.accepted, got.entry_count, got.read_valid, got.read_key,
						got.read_score);
			end else begin
				want = pending_replies.pop_front();
				if (got.accepted !== want.accepted || got.entry_count !== want.entry_count ||
						got.read_valid !== want.read_valid || got.read_key !== want.read_key ||
						got.read_score !== want.read_score) begin
					error_count++;
					if (error_count <= 10)
						$display({"reply differs: expected accepted %0b count %0d valid %0b ",
							"key %h score %0d, got accepted %0b count %0d valid %0b ",
							"key %h score %0d"},
							want.accepted, want.entry_count, want.read_valid, want.read_key,
							want.read_score, got.accepted, got.entry_count, got.read_valid,
							got.read_key, got.read_score);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("top_k_score_table: mismatch");
			$finish;
		end
	end

	task automatic test_empty_table();
		issue_op(tkst_pkg::MODE_READ, 16'h0000, 32'sd0, 4'd0);
		issue_op(tkst_pkg::MODE_READ, 16'hffff, 32'sd0, 4'd15);
		issue_op(tkst_pkg::MODE_NONE, 16'h5a5a, -32'sd1, 4'd7);
		issue_op(tkst_pkg::MODE_REMOVE, 16'h1234, 32'sd0, 4'd0);
	endtask

	task automatic test_extreme_values();
		issue_op(tkst_pkg::MODE_INSERT, 16'h0000, 32'sh80000000, 4'd0);
		issue_op(tkst_pkg::MODE_INSERT, 16'hffff, 32'sh7fffffff, 4'd0);
		issue_op(tkst_pkg::MODE_INSERT, 16'h8000, 32'sd0, 4'd0);
		issue_op(tkst_pkg::MODE_INSERT, 16'h7fff, -32'sd1, 4'd0);
		issue_op(tkst_pkg::MODE_READ, 16'h0000, 32'sd0, 4'd0);
		issue_op(tkst_pkg::MODE_READ, 16'h0000, 32'sd0, 4'd3);
		issue_op(tkst_pkg::MODE_READ, 16'h0000, 32'sd0, 4'd4);
		issue_op(tkst_pkg::MODE_REMOVE, 16'hffff, 32'sd0, 4'd0);
		issue_op(tkst_pkg::MODE_READ, 16'h0000, 32'sd0, 4'd0);
	endtask

	// Fills the table with tied scores, tries below and equal to the lowest entry, then reads and removes.
	task automatic test_full_table();
		logic signed [31:0] lowest;
		int i;
		issue_op(tkst_pkg::MODE_REMOVE, 16'h0000, 32'sd0, 4'd0);
		i = 0;
		while (table_fill < TABLE_DEPTH) begin
			issue_op(tkst_pkg::MODE_INSERT, 16'(i % 4), 32'((i % 5) * 10 - 20), 4'd0);
			i++;
		end
		lowest = table_scores[TABLE_DEPTH - 1];
		issue_op(tkst_pkg::MODE_INSERT, 16'h0042, lowest - 32'sd1, 4'd0);
		issue_op(tkst_pkg::MODE_INSERT, 16'h0043, lowest, 4'd0);
		issue_op(tkst_pkg::MODE_READ, 16'h0000, 32'sd0, 4'd15);
		issue_op(tkst_pkg::MODE_READ, 16'h0000, 32'sd0, 4'd14);
		issue_op(tkst_pkg::MODE_REMOVE, 16'h0002, 32'sd0, 4'd0);
		issue_op(tkst_pkg::MODE_READ, 16'h0000, 32'sd0, 4'd0);
	endtask

	task automatic test_random_traffic();
		tkst_pkg::mode_t m;
		logic [15:0] k;
		logic signed [31:0] s;
		int pick;
		bit removing;
		foreach (key_pool[j])
			key_pool[j] = 16'($urandom);
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 100 == 0) begin
				no_gaps  = ($urandom_range(0, 3) == 0);
				removing = ($urandom_range(0, 2) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < (removing ? 30 : 50))
				m = tkst_pkg::MODE_INSERT;
			else if (pick < (removing ? 65 : 62))
				m = tkst_pkg::MODE_REMOVE;
			else if (pick < 95)
				m = tkst_pkg::MODE_READ;
			else
				m = tkst_pkg::MODE_NONE;
			k = ($urandom_range(0, 3) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 7)];
			case ($urandom_range(0, 3))
				0: s = 32'($urandom_range(0, 6)) - 32'sd3;
				1: case ($urandom_range(0, 3))
					0: s = 32'sh80000000;
					1: s = 32'sh7fffffff;
					2: s = 32'sd0;
					default: s = -32'sd1;
				endcase
				default: s = 32'($urandom);
			endcase
			issue_op(m, k, s, 4'($urandom_range(0, 15)));
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		mode        = '0;
		player_key  = '0;
		new_score   = '0;
		slot_index  = '0;
		table_fill  = 0;
		no_gaps     = 1'b0;
		error_count = 0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_extreme_values();
		test_full_table();
		test_random_traffic();
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (error_count == 0 && pending_replies.size() == 0)
			$display("top_k_score_table: match");
		else
			$display("top_k_score_table: mismatch");
		$finish;
	end

endmodule
